/* hw/rtl/c3br_pkg.sv */
// ----------------------------------------------------------------------------
// c3br_pkg
// Shared types, widths and codes of the 3x3 border-renormalising filter.
// ----------------------------------------------------------------------------
package c3br_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int TAP_BITS       = 16;

  // exact accumulator of nine pixel*tap products
  localparam int ACC_W   = 36;
  localparam int ACCM_W  = ACC_W - 1;
  // sum of nine taps, and its magnitude
  localparam int FULL_W  = 20;
  localparam int MAG_W   = FULL_W - 1;
  localparam int PROD_W  = ACCM_W + MAG_W;
  // divider operands: numerator 2*|acc*S| + |P|<<F, divisor 2*(|P|<<F)
  localparam int UD_W    = MAG_W + COEF_FRAC_BITS;
  localparam int DEN_W   = UD_W + 1;
  localparam int NUM_W   = PROD_W + 2;

  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_MARGIN_FIX    = 3'd2;
  localparam logic [2:0] REG_KERNEL_TOP    = 3'd3;
  localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd4;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd5;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic                         kind;
    logic signed [PIXEL_BITS-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] filtered;
    logic                         frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_NORM,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/c3br_ram.sv */
// ----------------------------------------------------------------------------
// c3br_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c3br_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/c3br_div.sv */
// ----------------------------------------------------------------------------
// c3br_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module c3br_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [c3br_pkg::NUM_W-1:0] num,
  input  logic [c3br_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [c3br_pkg::NUM_W-1:0] quot
);

  localparam int NW = c3br_pkg::NUM_W;
  localparam int DW = c3br_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;   // numerator bits shift out, quotient bits shift in
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* hw/rtl/conv3x3_border_renorm_filter.sv */
// ----------------------------------------------------------------------------
// conv3x3_border_renorm_filter
// Streaming 3x3 convolution with dropped border taps and optional
// renormalisation of border results by full over partial kernel weight.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/stall); a drain
// transaction flushes one pending result once the frame's pixels are in.
// The result for a pixel leaves on the out_ channel once the pixel W+1
// places later has been taken (W = frame width). Both previous rows sit in
// one line RAM, one word per column, read and written back per pixel.
// Items are handled one at a time: a drain with nothing pending is dropped,
// any other item with no result passes the read step only, a plain result
// also runs the nine taps through one shared multiplier, and a renormalised
// border result adds a shift-add scale and then a bit-serial divider.
// An item is taken while the previous result still waits in the output
// register; a stalled receiver holds the block only when the next result is
// ready to go. Reset returns positions to the frame start and the
// registers to their defaults; the line RAM is not cleared, as unwritten
// words only feed taps outside the frame. Size writes restart the frame.
// ----------------------------------------------------------------------------
module conv3x3_border_renorm_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  c3br_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c3br_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [5:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int PB  = c3br_pkg::PIXEL_BITS;
  localparam int FB  = c3br_pkg::COEF_FRAC_BITS;
  localparam int TB  = c3br_pkg::TAP_BITS;
  localparam int AW  = c3br_pkg::ACC_W;
  localparam int AMW = c3br_pkg::ACCM_W;
  localparam int FW  = c3br_pkg::FULL_W;
  localparam int MW  = c3br_pkg::MAG_W;
  localparam int PW  = c3br_pkg::PROD_W;
  localparam int UW  = c3br_pkg::UD_W;
  localparam int NW  = c3br_pkg::NUM_W;
  localparam int DW  = c3br_pkg::DEN_W;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = RW + 1;
  localparam int QW  = WW + 1;
  localparam int SCW = $clog2(MW + 1);

  // configuration
  logic [10:0]   frame_width_r;
  logic [10:0]   frame_height_r;
  logic          margin_fix_r;
  logic [47:0]   kern_r [3];
  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  logic          size_wr;

  c3br_pkg::state_t state_r, state_nxt;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [QW-1:0] pend_r;

  logic signed [PB-1:0] win_r [3][3];
  logic signed [PB-1:0] x_r;
  logic                 drain_r;
  logic                 produce_r;
  logic                 accept;
  logic                 ignore_item;
  logic                 last_pos;

  // control decoded from state
  logic ram_re, ram_we, div_start, out_load;

  logic [2*PB-1:0] ram_rdata;
  logic signed [PB-1:0] up2, up1;

  // tap loop
  logic [1:0]           r_cnt, c_cnt;
  logic signed [AW-1:0] acc_r;
  logic signed [FW-1:0] part_r, full_r;
  logic signed [TB-1:0] tap_k;
  logic signed [PB-1:0] tap_x;
  logic                 tap_in;
  logic                 row_ok, col_ok;
  logic signed [PB+TB-1:0] tap_prod;

  // normalisation
  logic                 renorm;
  logic [AMW-1:0]       acc_mag;
  logic [MW-1:0]        full_mag, part_mag;
  logic [AMW-FB+1:0]    plain_q;
  logic                 neg_r;
  logic [PW-1:0]        mcand_r, prod_r;
  logic [MW-1:0]        mplier_r;
  logic [SCW-1:0]       scnt_r;
  logic [UW-1:0]        ud_r;
  logic [NW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  logic                 div_done;
  logic [NW-1:0]        div_quot;

  logic signed [PB-1:0] res_r;
  logic                 out_valid_r;
  c3br_pkg::out_item_t  out_r;

  function automatic logic signed [PB-1:0] sat(input logic [NW-1:0] mag, input logic neg);
    logic [NW-1:0] lim;
    lim = NW'(1) << (PB - 1);
    if (neg) begin
      sat = (mag > lim) ? PB'(lim) : PB'(~mag + 1'b1);
    end else begin
      sat = (mag >= lim) ? PB'(lim - 1'b1) : PB'(mag);
    end
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];
  assign size_wr    = cfg_wr && (cfg_idx == c3br_pkg::REG_FRAME_WIDTH ||
                                 cfg_idx == c3br_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd640;
      frame_height_r <= 11'd480;
      margin_fix_r   <= 1'b0;
      kern_r[0]      <= 48'd0;
      kern_r[1]      <= 48'd16384;
      kern_r[2]      <= 48'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        c3br_pkg::REG_FRAME_WIDTH:   frame_width_r  <= cfg_pwdata[10:0];
        c3br_pkg::REG_FRAME_HEIGHT:  frame_height_r <= cfg_pwdata[10:0];
        c3br_pkg::REG_MARGIN_FIX:    margin_fix_r   <= cfg_pwdata[0];
        c3br_pkg::REG_KERNEL_TOP:    kern_r[0]      <= cfg_pwdata[47:0];
        c3br_pkg::REG_KERNEL_MIDDLE: kern_r[1]      <= cfg_pwdata[47:0];
        c3br_pkg::REG_KERNEL_BOTTOM: kern_r[2]      <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      c3br_pkg::REG_FRAME_WIDTH:   cfg_prdata = 64'(frame_width_r);
      c3br_pkg::REG_FRAME_HEIGHT:  cfg_prdata = 64'(frame_height_r);
      c3br_pkg::REG_MARGIN_FIX:    cfg_prdata = 64'(margin_fix_r);
      c3br_pkg::REG_KERNEL_TOP:    cfg_prdata = 64'(kern_r[0]);
      c3br_pkg::REG_KERNEL_MIDDLE: cfg_prdata = 64'(kern_r[1]);
      c3br_pkg::REG_KERNEL_BOTTOM: cfg_prdata = 64'(kern_r[2]);
      default:                     cfg_prdata = '0;
    endcase
  end

  // clamped frame size
  always_comb begin
    if (frame_width_r < 11'd2) begin
      w_eff = WW'(2);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r < 11'd2) begin
      h_eff = HW'(2);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  // ---------------- sequencer ----------------
  assign accept      = in_valid && (state_r == c3br_pkg::ST_IDLE);
  assign ignore_item = (in_data.kind == c3br_pkg::KIND_DRAIN) && (pend_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      c3br_pkg::ST_IDLE:  if (in_valid && !ignore_item) state_nxt = c3br_pkg::ST_READ;
      c3br_pkg::ST_READ:  state_nxt = produce_r ? c3br_pkg::ST_MAC : c3br_pkg::ST_IDLE;
      c3br_pkg::ST_MAC:   if (r_cnt == 2'd2 && c_cnt == 2'd2) state_nxt = c3br_pkg::ST_NORM;
      c3br_pkg::ST_NORM:  state_nxt = renorm ? c3br_pkg::ST_SCALE : c3br_pkg::ST_OUT;
      c3br_pkg::ST_SCALE: if (scnt_r == SCW'(MW)) state_nxt = c3br_pkg::ST_DIV;
      c3br_pkg::ST_DIV:   if (div_done) state_nxt = c3br_pkg::ST_OUT;
      c3br_pkg::ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = c3br_pkg::ST_IDLE;
      default:            state_nxt = c3br_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != c3br_pkg::ST_IDLE);
    ram_re    = accept && !ignore_item;
    ram_we    = (state_r == c3br_pkg::ST_READ);
    div_start = (state_r == c3br_pkg::ST_SCALE) && (scnt_r == SCW'(MW));
    out_load  = (state_r == c3br_pkg::ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c3br_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- line RAM: {row above-above, row above} per column ----------
  c3br_ram #(
    .WIDTH (2 * PB),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col_r),
    .wdata ({up1, x_r}),
    .re    (ram_re),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  assign up2 = ram_rdata[2*PB-1:PB];
  assign up1 = ram_rdata[PB-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= (in_data.kind == c3br_pkg::KIND_DRAIN) ? '0 : in_data.pixel;
      drain_r   <= (in_data.kind == c3br_pkg::KIND_DRAIN);
      produce_r <= pend_r >= (QW'(w_eff) + 1'b1);
    end
  end

  // window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (state_r == c3br_pkg::ST_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= x_r;
    end
  end

  // ---------------- positions and pending count ----------------
  assign last_pos = (HW'(out_row_r) == h_eff - 1'b1) && (WW'(out_col_r) == w_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n || size_wr) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      pend_r    <= '0;
    end else begin
      if (state_r == c3br_pkg::ST_READ) begin
        if (WW'(in_col_r) + 1'b1 >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= (HW'(in_row_r) + 1'b1 >= h_eff) ? '0 : in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (!produce_r) begin
          pend_r <= pend_r + 1'b1;
        end
      end
      if (out_load) begin
        if (last_pos && drain_r) begin
          in_row_r  <= '0;
          in_col_r  <= '0;
          out_row_r <= '0;
          out_col_r <= '0;
          pend_r    <= '0;
        end else if (WW'(out_col_r) + 1'b1 >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= (HW'(out_row_r) + 1'b1 >= h_eff) ? '0 : out_row_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  // ---------------- tap loop: one tap per cycle ----------------
  assign tap_k    = kern_r[r_cnt][{c_cnt, 4'b0000} +: TB];
  assign tap_x    = win_r[r_cnt][c_cnt];
  assign row_ok   = (r_cnt == 2'd0) ? (out_row_r != '0) :
                    (r_cnt == 2'd2) ? (HW'(out_row_r) != h_eff - 1'b1) : 1'b1;
  assign col_ok   = (c_cnt == 2'd0) ? (out_col_r != '0) :
                    (c_cnt == 2'd2) ? (WW'(out_col_r) != w_eff - 1'b1) : 1'b1;
  assign tap_in   = row_ok && col_ok;
  assign tap_prod = tap_x * tap_k;

  always_ff @(posedge clk) begin
    if (state_r == c3br_pkg::ST_READ) begin
      r_cnt  <= '0;
      c_cnt  <= '0;
      acc_r  <= '0;
      part_r <= '0;
      full_r <= '0;
    end else if (state_r == c3br_pkg::ST_MAC) begin
      full_r <= full_r + FW'(tap_k);
      if (tap_in) begin
        acc_r  <= acc_r + AW'(tap_prod);
        part_r <= part_r + FW'(tap_k);
      end
      if (c_cnt == 2'd2) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + 1'b1;
      end else begin
        c_cnt <= c_cnt + 1'b1;
      end
    end
  end

  // ---------------- normalisation ----------------
  assign renorm   = margin_fix_r && (part_r < full_r) && (part_r != '0);
  assign acc_mag  = acc_r[AW-1] ? AMW'(-acc_r) : AMW'(acc_r);
  assign full_mag = full_r[FW-1] ? MW'(-full_r) : MW'(full_r);
  assign part_mag = part_r[FW-1] ? MW'(-part_r) : MW'(part_r);
  // plain path: round half away from zero after removing the fraction bits
  assign plain_q  = (AMW - FB + 2)'((36'(acc_mag) + (36'(1) << (FB - 1))) >> FB);

  assign div_num  = NW'({prod_r, 1'b0}) + NW'(ud_r);
  assign div_den  = {ud_r, 1'b0};

  always_ff @(posedge clk) begin
    unique case (state_r)
      c3br_pkg::ST_NORM: begin
        neg_r    <= acc_r[AW-1] ^ full_r[FW-1] ^ part_r[FW-1];
        mcand_r  <= PW'(acc_mag);
        mplier_r <= full_mag;
        prod_r   <= '0;
        scnt_r   <= '0;
        ud_r     <= {part_mag, {FB{1'b0}}};
        res_r    <= sat(NW'(plain_q), acc_r[AW-1]);
      end
      c3br_pkg::ST_SCALE: begin
        if (scnt_r != SCW'(MW)) begin
          if (mplier_r[0]) begin
            prod_r <= prod_r + mcand_r;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          scnt_r   <= scnt_r + 1'b1;
        end
      end
      c3br_pkg::ST_DIV: begin
        if (div_done) begin
          res_r <= sat(div_quot, neg_r);
        end
      end
      default: ;
    endcase
  end

  c3br_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.filtered  <= res_r;
      out_r.frame_end <= last_pos;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/c3br_chk.sv */
// ----------------------------------------------------------------------------
// c3br_chk
// Port-level checks of the 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
module c3br_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input c3br_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input c3br_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a pixel transaction keeps the block busy for at least the next cycle
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == c3br_pkg::KIND_PIXEL |=> in_stall)
    else $error("pixel taken without the block going busy");

  // a new result is only loaded while the input side is held
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without the block being busy");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind conv3x3_border_renorm_filter c3br_chk u_c3br_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
